// File: rtl/gray_box_blur_stream_defines.svh
// Assertion macros for the gray box blur block.
`ifndef GRAY_BOX_BLUR_STREAM_DEFINES_SVH
`define GRAY_BOX_BLUR_STREAM_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define GBB_ASSERT(lbl, clock, rstn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);
// checked in reset as well
`define GBB_ASSERT_ALWAYS(lbl, clock, prop, msg) \
    lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GBB_ASSERT(lbl, clock, rstn, prop, msg)
`define GBB_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

// File: rtl/gbb_pkg.sv
package gbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 31;

    localparam int W_REG_W   = 11;
    localparam int H_W       = 16;
    localparam int K_W       = 5;
    localparam int KK_W      = 2 * K_W;
    localparam int CS_W      = 13;
    localparam int FULL_W    = CS_W + 1;
    localparam int WS_W      = 18;
    localparam int GX_W      = 15;
    localparam int RECIP_W   = 13;
    localparam int PROD_W    = GX_W + RECIP_W;
    localparam int GRAY_SHIFT = 19;
    localparam logic [RECIP_W-1:0] GRAY_RECIP = 13'd5243;
    localparam int ROW_OUT_W = 16;
    localparam int COL_OUT_W = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [W_REG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [H_W-1:0]     HEIGHT_RST = 16'd480;
    localparam logic [K_W-1:0]     KERNEL_RST = 5'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KERNEL = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]           blurred;
        logic [ROW_OUT_W-1:0] center_row;
        logic [COL_OUT_W-1:0] center_col;
        logic                 last;
    } pix_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/gbb_ram.sv
module gbb_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gbb_div.sv
module gbb_div #(
    parameter int N = 18,
    parameter int D = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [N-1:0]         dividend,
    input  logic [D-1:0]         divisor,
    output gbb_pkg::div_status_t status,
    output logic [N-1:0]         quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     quo_reg;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [D:0]       rem_sh;
    logic             fits;
    logic [D:0]       rem_diff;
    logic             done;

    assign rem_sh   = {rem_reg, quo_reg[N-1]};
    assign fits     = rem_sh >= {1'b0, dsr_reg};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign done     = busy_reg && (cnt_reg == CNT_W'(N - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], fits};
            rem_reg <= fits ? rem_diff[D-1:0] : rem_sh[D-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done;
    assign quotient    = quo_reg;

endmodule

// File: rtl/gray_box_blur_stream.sv
// Streaming gray box blur. BGR pixels enter in raster order; each becomes a gray
// level, and for every interior pixel one result holds the box window sum
// divided by k*k (low 8 bits) with its center row and column. Steps per pixel:
// transfer, gray multiply, memory read-modify-write; a window-completing pixel
// then runs the 18-step serial divider after the update. The line store and
// column sums are synchronous memories with separate write and read ports
// that hold garbage until written; no clearing pass runs after reset. Register
// writes restart the image at row 0, column 0 and must be issued only while idle.
`include "gray_box_blur_stream_defines.svh"

module gray_box_blur_stream #(
    parameter int MAX_WIDTH  = gbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = gbb_pkg::MAX_KERNEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gbb_pkg::pix_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gbb_pkg::pix_out_t               out_data,
    input  logic                            cfg_en,
    input  logic [gbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LINES    = 2 * (MAX_KERNEL / 2);
    localparam int SIDE_MAX = LINES + 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int LS_W     = $clog2(LINES);
    localparam int SL_W     = $clog2(SIDE_MAX);
    localparam int GL_DEPTH = LINES * MAX_WIDTH;
    localparam int GA_W     = $clog2(GL_DEPTH);
    localparam int H_W      = gbb_pkg::H_W;
    localparam int K_W      = gbb_pkg::K_W;
    localparam int CS_W     = gbb_pkg::CS_W;
    localparam int FULL_W   = gbb_pkg::FULL_W;
    localparam int WS_W     = gbb_pkg::WS_W;
    localparam int KK_W     = gbb_pkg::KK_W;

    gbb_pkg::state_t state_reg, state_next;

    logic [gbb_pkg::W_REG_W-1:0] width_reg;
    logic [H_W-1:0]              height_reg;
    logic [K_W-1:0]              kernel_reg;
    logic [H_W-1:0]              row_reg;
    logic [COL_W-1:0]            col_reg;
    logic [LS_W-1:0]             ls_reg;
    logic [SL_W-1:0]             slot_reg;
    logic [WS_W-1:0]             ws_reg;
    logic [gbb_pkg::GX_W-1:0]    gx_reg;
    logic [gbb_pkg::PROD_W-1:0]  prod_reg;
    logic [FULL_W-1:0]           recent_reg [SIDE_MAX];
    logic [H_W-1:0]              res_row_reg;
    logic [COL_W-1:0]            res_col_reg;
    logic                        res_last_reg;
    gbb_pkg::pix_out_t           out_reg;
    logic                        out_valid_reg;

    logic [W_W-1:0]   w_eff;
    logic [H_W-1:0]   h_eff;
    logic [K_W-1:0]   k_eff;
    logic [K_W-2:0]   half;
    logic [K_W-1:0]   two_h;
    logic [K_W-1:0]   side;
    logic [KK_W-1:0]  kk;
    logic [COL_W-1:0] col_eff;
    logic [7:0]       ls8;
    logic [7:0]       th8;
    logic [LS_W-1:0]  leave_slot;
    logic [GA_W-1:0]  gl_raddr;
    logic [GA_W-1:0]  gl_waddr;
    logic [7:0]       gl_rdata;
    logic [CS_W-1:0]  cs_rdata;

    logic             in_fire;
    logic             upd;
    logic             div_start;
    logic             out_load;

    logic [7:0]        gray;
    logic [CS_W-1:0]   partial;
    logic [FULL_W-1:0] full;
    logic [7:0]        leave;
    logic [CS_W-1:0]   cs_wdata;
    logic [SL_W-1:0]   slot_use;
    logic [WS_W-1:0]   ws_base;
    logic [WS_W-1:0]   ws_sub;
    logic [WS_W-1:0]   ws_new;
    logic              row_ok;
    logic              emit;
    logic              col_end;
    logic              row_end;

    gbb_pkg::div_status_t div_status;
    logic [WS_W-1:0]      quotient;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = W_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(width_reg);
        h_eff = (height_reg == '0) ? H_W'(1) : height_reg;
        if (kernel_reg == '0)
            k_eff = K_W'(1);
        else if (32'(kernel_reg) > MAX_KERNEL)
            k_eff = K_W'(MAX_KERNEL);
        else
            k_eff = kernel_reg;
    end

    assign half    = k_eff[K_W-1:1];
    assign two_h   = {half, 1'b0};
    assign side    = two_h + K_W'(1);
    assign kk      = KK_W'(k_eff) * KK_W'(k_eff);
    assign col_eff = (W_W'(col_reg) >= w_eff) ? COL_W'(w_eff - W_W'(1)) : col_reg;

    assign ls8        = 8'(ls_reg);
    assign th8        = 8'(two_h);
    assign leave_slot = (ls8 >= th8) ? LS_W'(ls8 - th8) : LS_W'(ls8 + 8'(LINES) - th8);
    assign gl_raddr   = GA_W'(leave_slot) * GA_W'(MAX_WIDTH) + GA_W'(col_eff);
    assign gl_waddr   = GA_W'(ls_reg) * GA_W'(MAX_WIDTH) + GA_W'(col_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbb_pkg::ST_IDLE: if (in_valid) state_next = gbb_pkg::ST_MUL;
            gbb_pkg::ST_MUL:  state_next = gbb_pkg::ST_UPD;
            gbb_pkg::ST_UPD:  state_next = emit ? gbb_pkg::ST_DIV : gbb_pkg::ST_IDLE;
            gbb_pkg::ST_DIV:  if (div_status.done) state_next = gbb_pkg::ST_OUT;
            gbb_pkg::ST_OUT:  if (!out_valid_reg || out_ready) state_next = gbb_pkg::ST_IDLE;
            default:          state_next = gbb_pkg::ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        in_ready = 1'b0;
        upd      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            gbb_pkg::ST_IDLE: in_ready = 1'b1;
            gbb_pkg::ST_UPD:  upd = 1'b1;
            gbb_pkg::ST_OUT:  out_load = !out_valid_reg || out_ready;
            default:          ;
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign div_start = upd && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gbb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    gbb_ram #(
        .DW    (8),
        .DEPTH (GL_DEPTH)
    ) u_gray_lines (
        .clk   (clk),
        .we    (upd),
        .waddr (gl_waddr),
        .wdata (gray),
        .re    (in_fire),
        .raddr (gl_raddr),
        .rdata (gl_rdata)
    );

    gbb_ram #(
        .DW    (CS_W),
        .DEPTH (MAX_WIDTH)
    ) u_column_sums (
        .clk   (clk),
        .we    (upd),
        .waddr (col_eff),
        .wdata (cs_wdata),
        .re    (in_fire),
        .raddr (col_eff),
        .rdata (cs_rdata)
    );

    // gray = floor(x / 100) via reciprocal
    assign gray     = prod_reg[gbb_pkg::GRAY_SHIFT +: 8];
    assign partial  = (row_reg == '0) ? '0 : cs_rdata;
    assign full     = FULL_W'(partial) + FULL_W'(gray);
    assign row_ok   = 32'(row_reg) >= 32'(two_h);
    assign leave    = (half == '0) ? gray : (row_ok ? gl_rdata : 8'd0);
    assign cs_wdata = CS_W'(full - FULL_W'(leave));

    assign slot_use = (col_eff == '0) ? '0 : slot_reg;
    assign ws_base  = (col_eff == '0) ? '0 : ws_reg;
    assign ws_sub   = (32'(col_eff) >= 32'(side)) ? ws_base - WS_W'(recent_reg[slot_use])
                                                  : ws_base;
    assign ws_new   = ws_sub + WS_W'(full);

    assign emit    = row_ok && (32'(col_eff) >= 32'(two_h));
    assign col_end = (W_W'(col_eff) + W_W'(1)) >= w_eff;
    assign row_end = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gbb_pkg::WIDTH_RST;
            height_reg <= gbb_pkg::HEIGHT_RST;
            kernel_reg <= gbb_pkg::KERNEL_RST;
            row_reg    <= '0;
            col_reg    <= '0;
            ls_reg     <= '0;
            slot_reg   <= '0;
            ws_reg     <= '0;
        end
        else if (cfg_en && (cfg_index == gbb_pkg::CFG_WIDTH || cfg_index == gbb_pkg::CFG_HEIGHT
                            || cfg_index == gbb_pkg::CFG_KERNEL))
        begin
            case (cfg_index)
                gbb_pkg::CFG_WIDTH:  width_reg  <= cfg_data[gbb_pkg::W_REG_W-1:0];
                gbb_pkg::CFG_HEIGHT: height_reg <= cfg_data[H_W-1:0];
                gbb_pkg::CFG_KERNEL: kernel_reg <= cfg_data[K_W-1:0];
                default:             ;
            endcase
            row_reg  <= '0;
            col_reg  <= '0;
            ls_reg   <= '0;
            slot_reg <= '0;
            ws_reg   <= '0;
        end
        else if (upd)
        begin
            ws_reg <= ws_new;
            if (col_end)
            begin
                col_reg  <= '0;
                slot_reg <= '0;
                if (row_end)
                begin
                    row_reg <= '0;
                    ls_reg  <= '0;
                end
                else
                begin
                    row_reg <= row_reg + H_W'(1);
                    ls_reg  <= (32'(ls_reg) + 1 == LINES) ? '0 : ls_reg + LS_W'(1);
                end
            end
            else
            begin
                col_reg  <= col_eff + COL_W'(1);
                slot_reg <= (32'(slot_use) + 1 == 32'(side)) ? '0 : slot_use + SL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gx_reg <= gbb_pkg::GX_W'(32'd21 * 32'(in_data.red) + 32'd72 * 32'(in_data.green)
                                     + 32'd7 * 32'(in_data.blue));
        end
        if (state_reg == gbb_pkg::ST_MUL)
        begin
            prod_reg <= gbb_pkg::PROD_W'(gx_reg) * gbb_pkg::PROD_W'(gbb_pkg::GRAY_RECIP);
        end
        if (upd)
        begin
            recent_reg[slot_use] <= full;
            res_row_reg  <= row_reg - H_W'(half);
            res_col_reg  <= col_eff - COL_W'(half);
            res_last_reg <= row_end && col_end && (row_reg == h_eff - H_W'(1));
        end
        if (out_load)
        begin
            out_reg.blurred    <= quotient[7:0];
            out_reg.center_row <= res_row_reg;
            out_reg.center_col <= gbb_pkg::COL_OUT_W'(res_col_reg);
            out_reg.last       <= res_last_reg;
        end
    end

    gbb_div #(
        .N (WS_W),
        .D (KK_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ws_new),
        .divisor  (kk),
        .status   (div_status),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GBB_ASSERT(a_one_pixel_at_a_time, clk, rst_n, in_fire |=> !in_ready, "input taken while busy")
    `GBB_ASSERT(a_div_idle_on_start, clk, rst_n, div_start |-> !div_status.busy, "divider restarted while busy")
    `GBB_ASSERT(a_no_result_overwrite, clk, rst_n, out_load |-> (!out_valid_reg || out_ready), "pending result overwritten")
    `GBB_ASSERT(a_done_only_in_div, clk, rst_n, div_status.done |-> (state_reg == gbb_pkg::ST_DIV), "divider done outside divide state")

endmodule
